[src/ptts_pkg.sv]
package ptts_pkg;

  localparam int unsigned TASKS     = 8;
  localparam int unsigned TaskIdxW  = 3;
  localparam int unsigned TaskSelW  = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SettingW  = 33;
  localparam int unsigned CntW      = 16;

  localparam int unsigned EnBit     = 0;
  localparam int unsigned PeriodLsb = 1;
  localparam int unsigned DelayLsb  = 17;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic tick_load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic due_any;
    logic last;
  } dp_status_t;

endpackage

[src/periodic_task_tick_scheduler_unit.sv]
// Periodic task tick scheduler.
// Configuration: cfg_index_i selects one of eight task words, cfg_data_i carries
// enable (bit 0), period (bits 16:1) and start delay (bits 32:17) in ticks.
// A write loads that task's countdown with its delay. cfg_ready_o is always high;
// write only while the block is idle.
// Input: one request per tick on in_valid_i/in_ready_o; tick_i = 0 is a no-op.
// On a tick, every enabled task with a zero countdown is due and reloads with
// period minus one; other enabled tasks count down, disabled tasks hold.
// Output: one request per due task on out_valid_o/out_ready_i, in ascending
// task order, last_due_o set on the final one of the tick.
// Results: the accepted tick moves the control state to emit, and each due task
// then passes through the one-result output register; while the receiver is
// ready, results follow back to back, N per tick for N due tasks (at most 8).
// in_ready_o is low until a tick's last result is in the output register. A
// stalled receiver holds the output register and the walk over the pending tasks.
// Reset clears all settings and countdowns and drops any pending result.
module periodic_task_tick_scheduler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ptts_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ptts_pkg::SettingW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              tick_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ptts_pkg::TaskIdxW-1:0]     task_index_o,
  output logic                              last_due_o
);
  import ptts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  ptts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .tick_i      (tick_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .task_index_o (task_index_o),
    .last_due_o   (last_due_o)
  );

endmodule

[src/ptts_ctrl.sv]
module ptts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  tick_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  ptts_pkg::dp_status_t  status_i,
  output ptts_pkg::ctrl_cmd_t   cmd_o
);
  import ptts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   emit;

  assign accept = in_valid_i && in_ready_o;
  assign emit   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && tick_i && status_i.due_any) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit && status_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.tick_load = 1'b0;
    cmd_o.emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.tick_load = in_valid_i && tick_i;
      end
      ST_EMIT: begin
        cmd_o.emit = emit;
      end
      default: ;
    endcase
  end

  // hold a result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (emit)        out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/ptts_dp.sv]
module ptts_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [ptts_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ptts_pkg::SettingW-1:0]      cfg_data_i,
  input  ptts_pkg::ctrl_cmd_t                cmd_i,
  output ptts_pkg::dp_status_t               status_o,
  output logic [ptts_pkg::TaskIdxW-1:0]      task_index_o,
  output logic                               last_due_o
);
  import ptts_pkg::*;

  logic [SettingW-1:0] setting_q [TASKS];
  logic [CntW-1:0]     cnt_q     [TASKS];
  logic [CntW-1:0]     cnt_d     [TASKS];
  logic [TASKS-1:0]    due_now;
  logic [TASKS-1:0]    mask_q, mask_d;
  logic [TaskIdxW-1:0] idx_q;
  logic                last_q;
  logic [TaskIdxW-1:0] sel;
  logic                sel_last;
  logic                cfg_hit;

  assign cfg_hit = cfg_valid_i && (int'(cfg_index_i) < TASKS);

  always_comb begin
    for (int t = 0; t < TASKS; t++) begin
      logic [CntW-1:0] period;
      period     = setting_q[t][PeriodLsb +: CntW];
      due_now[t] = setting_q[t][EnBit] && (cnt_q[t] == '0);
      cnt_d[t]   = cnt_q[t];
      if (cmd_i.tick_load && setting_q[t][EnBit]) begin
        if (cnt_q[t] == '0) cnt_d[t] = (period == '0) ? '0 : period - 1'b1;
        else                cnt_d[t] = cnt_q[t] - 1'b1;
      end
      // a setting write reloads the countdown with the start delay
      if (cfg_hit && (cfg_index_i[TaskSelW-1:0] == TaskSelW'(t))) begin
        cnt_d[t] = cfg_data_i[DelayLsb +: CntW];
      end
    end
  end

  // pick the lowest pending task
  always_comb begin
    sel = '0;
    for (int t = TASKS - 1; t >= 0; t--) begin
      if (mask_q[t]) sel = TaskIdxW'(t);
    end
    sel_last = ((mask_q & (mask_q - 1'b1)) == '0);
  end

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.tick_load) mask_d = due_now;
    if (cmd_i.emit)      mask_d = mask_q & (mask_q - 1'b1);
  end

  assign status_o.due_any = |due_now;
  assign status_o.last    = sel_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TASKS; t++) begin
        setting_q[t] <= '0;
        cnt_q[t]     <= '0;
      end
      mask_q <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      for (int t = 0; t < TASKS; t++) begin
        cnt_q[t] <= cnt_d[t];
      end
      if (cfg_hit) begin
        setting_q[cfg_index_i[TaskSelW-1:0]] <= cfg_data_i;
      end
      mask_q <= mask_d;
      if (cmd_i.emit) begin
        idx_q  <= sel;
        last_q <= sel_last;
      end
    end
  end

  assign task_index_o = idx_q;
  assign last_due_o   = last_q;

endmodule

[src/ptts_checker.sv]
module ptts_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              tick_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ptts_pkg::TaskIdxW-1:0]     task_index_o,
  input logic                              last_due_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(task_index_o)
                                    && $stable(last_due_o))
    else $error("result changed while stalled");

  a_no_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !tick_i |=> in_ready_o)
    else $error("empty request left the block busy");

  a_busy_mid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_due_o |-> !in_ready_o)
    else $error("new request accepted before tick finished");

  a_next_ascends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_due_o |=>
      out_valid_o && (task_index_o > $past(task_index_o)))
    else $error("due tasks not sent back to back in ascending order");

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (.*);
